/* src/rptw_pkg.sv */
// Shared constants, types and the control program of the page table walker.
package rptw_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int LEVELS     = 5;
  localparam int INDEX_BITS = 9;

  localparam int VPN_W     = 45;
  localparam int PN_W      = 52;
  localparam int ROOT_W    = 6;
  localparam int OP_W      = 2;
  localparam int ENTRY_W   = PN_W + 1;
  localparam int FRAME_W   = $clog2(NUM_FRAMES);
  localparam int ADDR_W    = FRAME_W + INDEX_BITS;
  localparam int MEM_DEPTH = NUM_FRAMES * (2 ** INDEX_BITS);
  localparam int NFF_W     = $clog2(NUM_FRAMES + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VPN_EXT_W = (LEVELS * INDEX_BITS > VPN_W) ? LEVELS * INDEX_BITS : VPN_W;

  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_PTR,
    WS_LEAF
  } wsel_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACC,
    C_SKIP_OP,
    C_ROOT_OK,
    C_IS_MAP,
    C_IS_UNMAP,
    C_INVALID,
    C_LAST,
    C_PTR_OK,
    C_NFF_FREE,
    C_NOT_TAKEN,
    C_WIPE_MORE
  } cond_e;

  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] U_WIPE    = 5'd0;
  localparam logic [UPC_W-1:0] U_IDLE    = 5'd1;
  localparam logic [UPC_W-1:0] U_DISP    = 5'd2;
  localparam logic [UPC_W-1:0] U_ROOT    = 5'd3;
  localparam logic [UPC_W-1:0] U_ROOTBAD = 5'd4;
  localparam logic [UPC_W-1:0] U_OPSEL   = 5'd5;
  localparam logic [UPC_W-1:0] U_WRD     = 5'd6;
  localparam logic [UPC_W-1:0] U_WEVAL   = 5'd7;
  localparam logic [UPC_W-1:0] U_WLAST   = 5'd8;
  localparam logic [UPC_W-1:0] U_WADV    = 5'd9;
  localparam logic [UPC_W-1:0] U_WEXIT   = 5'd10;
  localparam logic [UPC_W-1:0] U_WLEAF   = 5'd11;
  localparam logic [UPC_W-1:0] U_WFOUND  = 5'd12;
  localparam logic [UPC_W-1:0] U_WCLEAR  = 5'd13;
  localparam logic [UPC_W-1:0] U_MLOOP   = 5'd14;
  localparam logic [UPC_W-1:0] U_MRD     = 5'd15;
  localparam logic [UPC_W-1:0] U_MEVAL   = 5'd16;
  localparam logic [UPC_W-1:0] U_MSKIP   = 5'd17;
  localparam logic [UPC_W-1:0] U_MCHK    = 5'd18;
  localparam logic [UPC_W-1:0] U_MFULL   = 5'd19;
  localparam logic [UPC_W-1:0] U_MTAKE   = 5'd20;
  localparam logic [UPC_W-1:0] U_MLEAF   = 5'd21;
  localparam logic [UPC_W-1:0] U_RESP    = 5'd22;
  localparam logic [UPC_W-1:0] U_RET     = 5'd23;

  typedef struct packed {
    logic             accept;
    logic             emit;
    logic             rd;
    logic             wr;
    wsel_e            wsel;
    logic             wipe;
    logic             adv_ptr;
    logic             skip_root;
    logic             take_frame;
    logic             set_found;
    logic             set_full;
    logic             full_if_map;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic op_skip;
    logic root_ok;
    logic is_map;
    logic is_unmap;
    logic invalid;
    logic last;
    logic ptr_ok;
    logic nff_free;
    logic wipe_more;
  } dp_status_t;

  // Control store. A word falls through to the next address unless its
  // condition holds, in which case it jumps to its target.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w        = '0;
    w.cond   = C_NEVER;
    w.wsel   = WS_ZERO;
    w.target = U_IDLE;
    unique case (upc)
      U_WIPE: begin
        w.wr = 1'b1; w.wsel = WS_ZERO; w.wipe = 1'b1;
        w.cond = C_WIPE_MORE; w.target = U_WIPE;
      end
      U_IDLE: begin
        w.accept = 1'b1; w.cond = C_NOT_ACC; w.target = U_IDLE;
      end
      U_DISP: begin
        w.cond = C_SKIP_OP; w.target = U_RESP;
      end
      U_ROOT: begin
        w.cond = C_ROOT_OK; w.target = U_OPSEL;
      end
      U_ROOTBAD: begin
        w.full_if_map = 1'b1; w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_OPSEL: begin
        w.cond = C_IS_MAP; w.target = U_MLOOP;
      end
      U_WRD: begin
        w.rd = 1'b1;
      end
      U_WEVAL: begin
        w.cond = C_INVALID; w.target = U_RESP;
      end
      U_WLAST: begin
        w.cond = C_LAST; w.target = U_WLEAF;
      end
      U_WADV: begin
        w.adv_ptr = 1'b1; w.cond = C_PTR_OK; w.target = U_WRD;
      end
      U_WEXIT: begin
        w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_WLEAF: begin
        w.cond = C_IS_UNMAP; w.target = U_WCLEAR;
      end
      U_WFOUND: begin
        w.set_found = 1'b1; w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_WCLEAR: begin
        w.wr = 1'b1; w.wsel = WS_ZERO; w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_MLOOP: begin
        w.cond = C_LAST; w.target = U_MLEAF;
      end
      U_MRD: begin
        w.rd = 1'b1;
      end
      U_MEVAL: begin
        w.adv_ptr = 1'b1; w.cond = C_PTR_OK; w.target = U_MLOOP;
      end
      U_MSKIP: begin
        w.skip_root = 1'b1;
      end
      U_MCHK: begin
        w.cond = C_NFF_FREE; w.target = U_MTAKE;
      end
      U_MFULL: begin
        w.set_full = 1'b1; w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_MTAKE: begin
        w.wr = 1'b1; w.wsel = WS_PTR; w.take_frame = 1'b1;
        w.cond = C_ALWAYS; w.target = U_MLOOP;
      end
      U_MLEAF: begin
        w.wr = 1'b1; w.wsel = WS_LEAF; w.cond = C_ALWAYS; w.target = U_RESP;
      end
      U_RESP: begin
        w.emit = 1'b1; w.cond = C_NOT_TAKEN; w.target = U_RESP;
      end
      U_RET: begin
        w.cond = C_ALWAYS; w.target = U_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/rptw_req_if.sv */
// Request channel: operation, virtual page number and page number to map.
interface rptw_req_if;
  logic                           valid;
  logic                           ready;
  logic [rptw_pkg::OP_W-1:0]      opcode;
  logic [rptw_pkg::VPN_W-1:0]     vpn;
  logic [rptw_pkg::PN_W-1:0]      ppn;

  modport source (output valid, opcode, vpn, ppn, input ready);
  modport sink   (input valid, opcode, vpn, ppn, output ready);
endinterface

/* src/rptw_rsp_if.sv */
// Response channel: translated page number, mapped flag and status.
interface rptw_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rptw_pkg::PN_W-1:0] result_ppn;
  logic                      mapped;
  logic                      status;

  modport source (output valid, result_ppn, mapped, status, input ready);
  modport sink   (input valid, result_ppn, mapped, status, output ready);
endinterface

/* src/rptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rptw_useq.sv */
// Microcode sequencer: step counter, control store and branch selection.
module rptw_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rptw_pkg::dp_status_t status_i,
  input  logic                 req_fire_i,
  input  logic                 rsp_fire_i,
  output rptw_pkg::ctrl_t      ctrl_o
);

  logic [rptw_pkg::UPC_W-1:0] upc_q;
  logic [rptw_pkg::UPC_W-1:0] upc_d;
  rptw_pkg::ctrl_t            ctrl;
  logic                       take;

  assign ctrl = rptw_pkg::ucode(upc_q);

  always_comb begin
    unique case (ctrl.cond)
      rptw_pkg::C_NEVER:     take = 1'b0;
      rptw_pkg::C_ALWAYS:    take = 1'b1;
      rptw_pkg::C_NOT_ACC:   take = !req_fire_i;
      rptw_pkg::C_SKIP_OP:   take = status_i.op_skip;
      rptw_pkg::C_ROOT_OK:   take = status_i.root_ok;
      rptw_pkg::C_IS_MAP:    take = status_i.is_map;
      rptw_pkg::C_IS_UNMAP:  take = status_i.is_unmap;
      rptw_pkg::C_INVALID:   take = status_i.invalid;
      rptw_pkg::C_LAST:      take = status_i.last;
      rptw_pkg::C_PTR_OK:    take = status_i.ptr_ok;
      rptw_pkg::C_NFF_FREE:  take = status_i.nff_free;
      rptw_pkg::C_NOT_TAKEN: take = !rsp_fire_i;
      rptw_pkg::C_WIPE_MORE: take = status_i.wipe_more;
      default:               take = 1'b1;
    endcase
    upc_d = take ? ctrl.target : upc_q + rptw_pkg::UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rptw_pkg::U_WIPE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

/* src/rptw_dpath.sv */
// Walk datapath: request registers, level and frame registers, frame
// allocator, clearing counter and the frame memory.
module rptw_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rptw_pkg::ctrl_t               ctrl_i,
  input  logic                          req_fire_i,
  input  logic [rptw_pkg::OP_W-1:0]     opcode_i,
  input  logic [rptw_pkg::VPN_W-1:0]    vpn_i,
  input  logic [rptw_pkg::PN_W-1:0]     ppn_i,
  input  logic [rptw_pkg::ROOT_W-1:0]   root_i,
  output rptw_pkg::dp_status_t          status_o,
  output logic [rptw_pkg::PN_W-1:0]     entry_pn_o
);

  logic [rptw_pkg::OP_W-1:0]       op_q;
  logic [rptw_pkg::VPN_W-1:0]      vpn_q;
  logic [rptw_pkg::PN_W-1:0]       ppn_q;
  logic [rptw_pkg::FRAME_W-1:0]    frame_q;
  logic [rptw_pkg::LVL_W-1:0]      lvl_q;
  logic [rptw_pkg::NFF_W-1:0]      nff_q;
  logic [rptw_pkg::ADDR_W-1:0]     wipe_q;

  logic [rptw_pkg::VPN_EXT_W-1:0]  vpn_ext;
  logic [rptw_pkg::INDEX_BITS-1:0] idx_arr [rptw_pkg::LEVELS];
  logic [rptw_pkg::ADDR_W-1:0]     walk_addr;
  logic [rptw_pkg::ADDR_W-1:0]     waddr;
  logic [rptw_pkg::ENTRY_W-1:0]    wdata;
  logic [rptw_pkg::ENTRY_W-1:0]    rdata;
  logic [rptw_pkg::PN_W-1:0]       entry_pn;
  logic                            entry_valid;
  logic                            ptr_ok;
  logic                            nff_is_root;

  // Index bits above the virtual page number read as zero.
  assign vpn_ext = rptw_pkg::VPN_EXT_W'(vpn_q);

  for (genvar l = 0; l < rptw_pkg::LEVELS; l++) begin : g_idx
    assign idx_arr[l] =
      vpn_ext[rptw_pkg::INDEX_BITS*(rptw_pkg::LEVELS-1-l) +: rptw_pkg::INDEX_BITS];
  end

  assign walk_addr = {frame_q, idx_arr[lvl_q]};
  assign waddr     = ctrl_i.wipe ? wipe_q : walk_addr;

  always_comb begin
    unique case (ctrl_i.wsel)
      rptw_pkg::WS_ZERO: wdata = '0;
      rptw_pkg::WS_PTR:  wdata = {rptw_pkg::PN_W'(nff_q), 1'b1};
      rptw_pkg::WS_LEAF: wdata = {ppn_q, 1'b1};
      default:           wdata = '0;
    endcase
  end

  rptw_ram #(
    .WIDTH (rptw_pkg::ENTRY_W),
    .DEPTH (rptw_pkg::MEM_DEPTH)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd),
    .raddr_i (walk_addr),
    .rdata_o (rdata)
  );

  assign entry_valid = rdata[0];
  assign entry_pn    = rdata[rptw_pkg::ENTRY_W-1:1];
  // A valid pointer past the last frame counts as a missing table.
  assign ptr_ok      = entry_valid && (entry_pn < rptw_pkg::PN_W'(rptw_pkg::NUM_FRAMES));
  assign nff_is_root = rptw_pkg::PN_W'(nff_q) == rptw_pkg::PN_W'(root_i);

  always_ff @(posedge clk_i) begin
    if (req_fire_i) begin
      op_q  <= opcode_i;
      vpn_q <= vpn_i;
      ppn_q <= ppn_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      lvl_q   <= '0;
      nff_q   <= '0;
      wipe_q  <= '0;
    end else begin
      if (ctrl_i.wipe) begin
        wipe_q <= wipe_q + rptw_pkg::ADDR_W'(1);
      end
      if (req_fire_i) begin
        frame_q <= rptw_pkg::FRAME_W'(root_i);
        lvl_q   <= '0;
      end else if (ctrl_i.adv_ptr && ptr_ok) begin
        frame_q <= entry_pn[rptw_pkg::FRAME_W-1:0];
        lvl_q   <= lvl_q + rptw_pkg::LVL_W'(1);
      end else if (ctrl_i.take_frame) begin
        frame_q <= rptw_pkg::FRAME_W'(nff_q);
        lvl_q   <= lvl_q + rptw_pkg::LVL_W'(1);
      end
      if ((ctrl_i.skip_root && nff_is_root) || ctrl_i.take_frame) begin
        nff_q <= nff_q + rptw_pkg::NFF_W'(1);
      end
    end
  end

  assign status_o.op_skip   = op_q == rptw_pkg::OP_NONE;
  assign status_o.root_ok   =
    rptw_pkg::PN_W'(root_i) < rptw_pkg::PN_W'(rptw_pkg::NUM_FRAMES);
  assign status_o.is_map    = op_q == rptw_pkg::OP_MAP;
  assign status_o.is_unmap  = op_q == rptw_pkg::OP_UNMAP;
  assign status_o.invalid   = !entry_valid;
  assign status_o.last      = lvl_q == rptw_pkg::LVL_W'(rptw_pkg::LEVELS - 1);
  assign status_o.ptr_ok    = ptr_ok;
  assign status_o.nff_free  =
    rptw_pkg::PN_W'(nff_q) < rptw_pkg::PN_W'(rptw_pkg::NUM_FRAMES);
  assign status_o.wipe_more = wipe_q != rptw_pkg::ADDR_W'(rptw_pkg::MEM_DEPTH - 1);

  assign entry_pn_o = entry_pn;

endmodule

/* src/radix_page_table_walker.sv */
// Radix page table walker top level: root register, response registers and
// the channel handshakes around the sequencer and the walk datapath.
//
//   channel   direction  handshake        payload
//   req_i     in         valid / ready    opcode, vpn, ppn
//   rsp_o     out        valid / ready    result_ppn, mapped, status
//   cfg       in         cfg_we_i         cfg_data_i (root_frame)
//
// After reset a clearing pass writes zero to all 32768 frame memory entries,
// one per cycle; no request is taken until it ends.
// One request at a time. Every decision is one microcode step and each table
// level walked costs one frame memory read; a map writes its leaf entry
// without a read and allocates a new frame for each missing level. A
// response that is not taken holds the block in its response step.
module radix_page_table_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rptw_pkg::ROOT_W-1:0]   cfg_data_i,
  rptw_req_if.sink                      req_i,
  rptw_rsp_if.source                    rsp_o
);

  rptw_pkg::ctrl_t             ctrl;
  rptw_pkg::dp_status_t        status;
  logic [rptw_pkg::PN_W-1:0]   entry_pn;
  logic [rptw_pkg::ROOT_W-1:0] root_q;
  logic [rptw_pkg::PN_W-1:0]   result_ppn_q;
  logic                        mapped_q;
  logic                        status_q;
  logic                        req_fire;
  logic                        rsp_fire;

  assign req_i.ready = ctrl.accept;
  assign rsp_o.valid = ctrl.emit;
  assign req_fire    = req_i.valid && ctrl.accept;
  assign rsp_fire    = rsp_o.ready && ctrl.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      result_ppn_q <= '0;
      mapped_q     <= 1'b0;
      status_q     <= 1'b0;
    end else begin
      if (ctrl.set_found) begin
        result_ppn_q <= entry_pn;
        mapped_q     <= 1'b1;
      end
      if (ctrl.set_full || (ctrl.full_if_map && status.is_map)) begin
        status_q <= 1'b1;
      end
    end
  end

  assign rsp_o.result_ppn = result_ppn_q;
  assign rsp_o.mapped     = mapped_q;
  assign rsp_o.status     = status_q;

  rptw_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .req_fire_i (req_fire),
    .rsp_fire_i (rsp_fire),
    .ctrl_o     (ctrl)
  );

  rptw_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .req_fire_i (req_fire),
    .opcode_i   (req_i.opcode),
    .vpn_i      (req_i.vpn),
    .ppn_i      (req_i.ppn),
    .root_i     (root_q),
    .status_o   (status),
    .entry_pn_o (entry_pn)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the radix page table walker with its own table model.
`timescale 1ns / 1ps

module testbench;
  import rptw_pkg::*;

  localparam int ENTRIES     = 2 ** INDEX_BITS;
  localparam int PREFIX_W    = VPN_W - INDEX_BITS;
  localparam int POOL_N      = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int LIMIT       = 800000;

  localparam logic [VPN_W-1:0] VPN_ALT = VPN_W'({23{2'b01}});
  localparam logic [PN_W-1:0]  PPN_ALT = PN_W'({26{2'b10}});

  typedef struct packed {
    logic [PN_W-1:0] result_ppn;
    logic            mapped;
    logic            status;
  } walk_rsp_t;

  typedef struct {
    logic              cfg;
    logic [ROOT_W-1:0] root;
    logic [OP_W-1:0]   op;
    logic [VPN_W-1:0]  vpn;
    logic [PN_W-1:0]   ppn;
    logic              known;
    walk_rsp_t         want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [ROOT_W-1:0]   cfg_data;

  rptw_req_if req_if ();
  rptw_rsp_if rsp_if ();

  radix_page_table_walker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #4 clk = ~clk;

  // Model state: frame memory, allocation counter and root register.
  logic [ENTRY_W-1:0]  frame_mem [MEM_DEPTH];
  int unsigned         alloc_ptr;
  logic [ROOT_W-1:0]   root_frame_q;

  walk_rsp_t           pending_rsp [$];
  script_row_t         script [$];
  logic [VPN_W-1:0]    mapped_vpns [$];
  logic [PREFIX_W-1:0] prefix_pool [POOL_N];

  int                  err_count = 0;
  int                  gap_pct;
  int                  stall_pct;
  logic                hold_go = 1'b0;
  int                  cycle_cnt = 0;

  function automatic int unsigned entry_addr(input int unsigned frame,
                                             input logic [VPN_W-1:0] vpn, input int lvl);
    logic [VPN_W-1:0] idx;
    idx = (vpn >> (INDEX_BITS * (LEVELS - 1 - lvl))) & VPN_W'(ENTRIES - 1);
    return frame * ENTRIES + 32'(idx);
  endfunction

  // Walks the model table for one request and updates it the way the block does.
  function automatic walk_rsp_t translate(input logic [OP_W-1:0] op,
                                          input logic [VPN_W-1:0] vpn,
                                          input logic [PN_W-1:0] ppn);
    walk_rsp_t          r;
    int unsigned        frame;
    int unsigned        addr;
    logic [ENTRY_W-1:0] ent;
    logic [PN_W-1:0]    pn;
    r = '0;
    frame = root_frame_q;
    if (op == OP_NONE) return r;
    if (frame >= NUM_FRAMES) begin
      r.status = (op == OP_MAP);
      return r;
    end
    if (op != OP_MAP) begin
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
        addr = entry_addr(frame, vpn, lvl);
        ent  = frame_mem[addr];
        pn   = ent[PN_W:1];
        if (!ent[0]) return r;
        if (lvl == LEVELS - 1) begin
          if (op == OP_QUERY) begin
            r.result_ppn = pn;
            r.mapped     = 1'b1;
          end else begin
            frame_mem[addr] = '0;
          end
          return r;
        end
        // A valid pointer outside the frame range ends the walk like an invalid one.
        if (pn >= NUM_FRAMES) return r;
        frame = 32'(pn);
      end
      return r;
    end
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      addr = entry_addr(frame, vpn, lvl);
      ent  = frame_mem[addr];
      pn   = ent[PN_W:1];
      if (ent[0] && pn < NUM_FRAMES) begin
        frame = 32'(pn);
        continue;
      end
      if (alloc_ptr == root_frame_q) alloc_ptr++;
      if (alloc_ptr >= NUM_FRAMES) begin
        r.status = 1'b1;
        return r;
      end
      frame = alloc_ptr;
      alloc_ptr++;
      frame_mem[addr] = {PN_W'(frame), 1'b1};
    end
    frame_mem[entry_addr(frame, vpn, LEVELS - 1)] = {ppn, 1'b1};
    return r;
  endfunction

  function automatic void add_req(input logic [OP_W-1:0] op, input logic [VPN_W-1:0] vpn,
                                  input logic [PN_W-1:0] ppn, input logic known,
                                  input logic [PN_W-1:0] w_ppn, input logic w_mapped,
                                  input logic w_status);
    script_row_t row;
    row.cfg   = 1'b0;
    row.root  = '0;
    row.op    = op;
    row.vpn   = vpn;
    row.ppn   = ppn;
    row.known = known;
    row.want  = '{result_ppn: w_ppn, mapped: w_mapped, status: w_status};
    script.push_back(row);
  endfunction

  function automatic void add_root(input logic [ROOT_W-1:0] root);
    script_row_t row;
    row       = '{default: '0};
    row.cfg   = 1'b1;
    row.root  = root;
    script.push_back(row);
  endfunction

  // Offers one request after a random gap and records its expected response
  // at the edge where it is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VPN_W-1:0] vpn,
                              input logic [PN_W-1:0] ppn, input logic known,
                              input walk_rsp_t want);
    walk_rsp_t got;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.vpn    <= vpn;
    req_if.ppn    <= ppn;
    do @(posedge clk); while (!req_if.ready);
    got = translate(op, vpn, ppn);
    pending_rsp.push_back(known ? want : got);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_root(input logic [ROOT_W-1:0] root);
    cfg_we       <= 1'b1;
    cfg_data     <= root;
    root_frame_q  = root;
    @(negedge clk);
    cfg_we       <= 1'b0;
  endtask

  // Most requests reuse a few table paths so that maps keep succeeding after
  // the free frames are gone; the rest are exact repeats, extremes and noise.
  task automatic pick_request(output logic [OP_W-1:0] op, output logic [VPN_W-1:0] vpn,
                              output logic [PN_W-1:0] ppn);
    int r;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(99);
    if (r < 40) op = OP_MAP;
    else if (r < 75) op = OP_QUERY;
    else if (r < 90) op = OP_UNMAP;
    else op = OP_NONE;
    if (k < 55) begin
      vpn = {prefix_pool[$urandom_range(POOL_N - 1)], INDEX_BITS'($urandom)};
    end else if (k < 80 && mapped_vpns.size() != 0) begin
      vpn = mapped_vpns[$urandom_range(mapped_vpns.size() - 1)];
    end else if (k < 88) begin
      vpn = $urandom_range(1) ? '1 : '0;
    end else begin
      vpn = VPN_W'({$urandom, $urandom});
    end
    // Small page numbers turn into in-range pointers when a leaf table becomes the root.
    if ($urandom_range(99) < 30) ppn = PN_W'($urandom_range(NUM_FRAMES - 1));
    else ppn = PN_W'({$urandom, $urandom});
    if (op == OP_MAP) begin
      mapped_vpns.push_back(vpn);
      if (mapped_vpns.size() > 64) void'(mapped_vpns.pop_front());
    end
  endtask

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    walk_rsp_t exp_rsp;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: result_ppn %h mapped %b status %b",
               rsp_if.result_ppn, rsp_if.mapped, rsp_if.status);
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_if.result_ppn !== exp_rsp.result_ppn) begin
          $error("result_ppn: expected %h, actual %h", exp_rsp.result_ppn, rsp_if.result_ppn);
          err_count++;
        end
        if (rsp_if.mapped !== exp_rsp.mapped) begin
          $error("mapped: expected %b, actual %b", exp_rsp.mapped, rsp_if.mapped);
          err_count++;
        end
        if (rsp_if.status !== exp_rsp.status) begin
          $error("status: expected %b, actual %b", exp_rsp.status, rsp_if.status);
          err_count++;
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [VPN_W-1:0]  vpn;
    logic [PN_W-1:0]   ppn;
    logic [ROOT_W-1:0] phase_root;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_NONE;
    req_if.vpn    <= '0;
    req_if.ppn    <= '0;
    gap_pct       = 0;
    stall_pct     = 0;
    for (int i = 0; i < MEM_DEPTH; i++) frame_mem[i] = '0;
    alloc_ptr    = 0;
    root_frame_q = '0;
    prefix_pool[0] = '0;
    prefix_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) prefix_pool[i] = PREFIX_W'({$urandom, $urandom});

    // Empty table, extremes, remap, unmap twice, unused opcode.
    add_req(OP_QUERY, '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_UNMAP, '1, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_NONE,  '1, '1, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_MAP,   '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, '0, '1, 1'b1, '0, 1'b1, 1'b0);
    add_req(OP_MAP,   '1, '1, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, '1, '0, 1'b1, '1, 1'b1, 1'b0);
    add_req(OP_MAP,   '1, PPN_ALT, 1'b0, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, '1, '0, 1'b0, '0, 1'b0, 1'b0);
    add_req(OP_UNMAP, '1, '1, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, '1, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_UNMAP, '1, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, VPN_W'(1), '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_MAP,   VPN_ALT, PPN_ALT, 1'b0, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, VPN_ALT, '0, 1'b0, '0, 1'b0, 1'b0);
    // Leaf for vpn zero now holds a value past the last frame.
    add_req(OP_MAP,   '0, PN_W'(1000), 1'b0, '0, 1'b0, 1'b0);
    // Frame 4 is the leaf table of vpn zero; as root its entry is a bad pointer.
    add_root(ROOT_W'(4));
    add_req(OP_QUERY, '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_UNMAP, '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_req(OP_MAP,   '0, PN_W'(7), 1'b0, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_root('1);
    add_req(OP_MAP,   VPN_W'(1), PN_W'(3), 1'b0, '0, 1'b0, 1'b0);
    add_req(OP_QUERY, VPN_W'(1), '0, 1'b0, '0, 1'b0, 1'b0);
    add_root('0);
    add_req(OP_QUERY, '0, '0, 1'b0, '0, 1'b0, 1'b0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].cfg) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        drain();
        write_root(script[i].root);
      end else begin
        send_request(script[i].op, script[i].vpn, script[i].ppn, script[i].known,
                     script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      drain();
      case (phase)
        1, 6:    phase_root = '1;
        3:       phase_root = ROOT_W'($urandom);
        5:       phase_root = ROOT_W'($urandom_range(alloc_ptr > 1 ? alloc_ptr - 1 : 0));
        default: phase_root = '0;
      endcase
      write_root(phase_root);
      case (phase % 4)
        0: begin
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          gap_pct = 66; stall_pct = 0;
        end
        2: begin
          gap_pct = 0;  stall_pct = 66;
        end
        default: begin
          gap_pct = 17; stall_pct = 17;
        end
      endcase
      // The receiver holds off while requests keep coming, so the block backs up.
      if (phase == 4) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_request(op, vpn, ppn);
        send_request(op, vpn, ppn, 1'b0, '0);
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/rptw_pkg.sv
src/rptw_req_if.sv
src/rptw_rsp_if.sv
src/rptw_ram.sv
src/rptw_useq.sv
src/rptw_dpath.sv
src/radix_page_table_walker.sv
sim/testbench.sv
